FILE: sv/mvna_pkg.sv
// Shared constants and types for the mesh vertex normal averaging block.
// No dependencies.
`default_nettype none
package mvna_pkg;

   localparam int unsigned VERTEX_DEPTH_DEF   = 16384;
   localparam int unsigned TRIANGLE_DEPTH_DEF = 32768;

   localparam int POS_W  = 32;
   localparam int IDX_W  = 14;
   localparam int SLOT_W = 15;
   localparam int NRM_W  = 16;
   localparam int CSR_W  = 16;
   localparam int M_W    = 30;   // scaled magnitude width
   localparam int Q_FRAC = 14;   // Q2.14 fraction bits

   typedef enum logic [1:0] {
      MODE_VERTEX = 2'd0,
      MODE_TRI    = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   localparam logic CSR_TRI_COUNT = 1'b0;
   localparam logic CSR_MIN_Y     = 1'b1;

   localparam logic [CSR_W-1:0]        TRI_COUNT_RST = 16'd0;
   localparam logic signed [NRM_W-1:0] MIN_Y_RST     = 16'sd3277;

endpackage
`default_nettype wire

FILE: sv/mesh_vertex_normal_average.sv
// Mesh vertex normal averaging: vertex/triangle stores, scan, normalize.
// Depends on mvna_pkg.
//
// Use: drive req_* with start while busy is low. Mode 0 writes a vertex
// position, mode 1 writes a triangle's three corners; both take effect at
// the accepting edge and give no result word. Mode 2 queries one vertex: busy
// rises and the block scans triangles 0..triangle_count-1 (capped at the
// triangle depth), summing the face normal of every triangle that has the
// vertex as a corner, then scales the sum to unit length in Q2.14 and raises
// y to at least min_normal_y. The result word appears for one cycle with
// rsp_strobe; the receiver cannot stall, so it must take it then.
// The scan reads one triangle per cycle from the triangle memory, pausing at
// each match; each match costs three vertex memory reads and six passes
// through one 33x33 multiplier. Normalizing shifts one bit a cycle, the square
// root gives one bit a cycle, and the three divides run one after another.
// Mode 3 is ignored. Reset returns the control to idle and the registers to
// their defaults; the memories are undefined until written.
// The user must make csr_* writes only while idle; the block does not enforce
// this and takes them with no wait.
`default_nettype none
module mesh_vertex_normal_average import mvna_pkg::*; #(
   parameter int unsigned VERTEX_DEPTH   = VERTEX_DEPTH_DEF,
   parameter int unsigned TRIANGLE_DEPTH = TRIANGLE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [1:0]               req_mode,
   input  wire logic [SLOT_W-1:0]        req_slot,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [POS_W-1:0]  req_pos_z,
   input  wire logic [IDX_W-1:0]         req_corner_a,
   input  wire logic [IDX_W-1:0]         req_corner_b,
   input  wire logic [IDX_W-1:0]         req_corner_c,
   output      logic                     rsp_strobe,
   output      logic [IDX_W-1:0]         rsp_vertex_id,
   output      logic signed [NRM_W-1:0]  rsp_normal_x,
   output      logic signed [NRM_W-1:0]  rsp_normal_y,
   output      logic signed [NRM_W-1:0]  rsp_normal_z,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [CSR_W-1:0]         csr_wdata
);

   localparam int VA_W  = $clog2(VERTEX_DEPTH);
   localparam int TA_W  = (TRIANGLE_DEPTH > 1) ? $clog2(TRIANGLE_DEPTH) : 1;
   localparam int TC_W  = ($clog2(TRIANGLE_DEPTH + 1) > 16) ? $clog2(TRIANGLE_DEPTH + 1) : 17;
   localparam int D_W   = POS_W + 1;
   localparam int P_W   = 2 * D_W;
   localparam int ACC_W = P_W + 3 + $clog2(TRIANGLE_DEPTH + 1);
   localparam int SQ_W  = 2 * M_W;
   localparam int L2_W  = SQ_W + 2;
   localparam int R_W   = 64;
   localparam int LEN_W = M_W + 1;
   localparam int REM_W = M_W + Q_FRAC + 2;
   localparam int DV_W  = LEN_W + 16;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_V0, ST_V1, ST_V2, ST_MUL, ST_ACC, ST_ABS, ST_NORM,
      ST_SQ, ST_SQACC, ST_SQRT, ST_DIVLD, ST_DIV, ST_FIN
   } state_type;

   // storage
   logic [3*POS_W-1:0] vtx_mem [VERTEX_DEPTH];
   logic [3*IDX_W-1:0] tri_mem [TRIANGLE_DEPTH];
   logic [3*POS_W-1:0] vtx_rd_ff;
   logic [3*IDX_W-1:0] tri_rd_ff;
   logic [VA_W-1:0]    vtx_raddr;

   state_type                 state_ff;
   logic [CSR_W-1:0]          tri_count_ff;
   logic signed [NRM_W-1:0]   min_y_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [TC_W-1:0]           t_ff;
   logic                      pend_ff;
   logic [IDX_W-1:0]          corner_ff [3];
   logic [2:0]                cv_ff;
   logic signed [POS_W-1:0]   p0_ff [3];
   logic signed [POS_W-1:0]   p1_ff [3];
   logic signed [D_W-1:0]     a_ff [3];
   logic signed [D_W-1:0]     b_ff [3];
   logic [2:0]                step_ff;
   logic signed [P_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic [ACC_W-1:0]          mag_ff [3];
   logic [2:0]                neg_ff;
   logic [1:0]                k_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [L2_W-1:0]           len2_ff;
   logic [R_W-1:0]            rv_ff;
   logic [R_W-1:0]            root_ff;
   logic [R_W-1:0]            sqb_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [3:0]                i_ff;
   logic [15:0]               qcur_ff;
   logic [15:0]               q_ff [3];
   logic                      rsp_strobe_ff;
   logic [IDX_W-1:0]          rsp_id_ff;
   logic signed [NRM_W-1:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic                      accept;
   logic [TC_W-1:0]           scan_n;
   logic [IDX_W-1:0]          tc0, tc1, tc2;
   logic                      match;
   logic signed [D_W-1:0]     opa, opb;
   logic [ACC_W-1:0]          orv;
   logic [M_W-1:0]            m_sel;
   logic [LEN_W-1:0]          len;
   logic [R_W-1:0]            sq_try;
   logic [DV_W-1:0]           dv;
   logic signed [POS_W-1:0]   p2 [3];
   logic signed [NRM_W-1:0]   res_x, res_y, res_z;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign scan_n = (32'(tri_count_ff) > TRIANGLE_DEPTH) ? TC_W'(TRIANGLE_DEPTH)
                                                        : TC_W'(tri_count_ff);
   assign tc0    = tri_rd_ff[IDX_W-1:0];
   assign tc1    = tri_rd_ff[2*IDX_W-1:IDX_W];
   assign tc2    = tri_rd_ff[3*IDX_W-1:2*IDX_W];
   assign match  = pend_ff && ({1'b0, tc0} == slot_ff || {1'b0, tc1} == slot_ff ||
                               {1'b0, tc2} == slot_ff);
   assign orv    = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign len    = root_ff[LEN_W-1:0];
   assign sq_try = root_ff + sqb_ff;
   assign dv     = DV_W'(len) << i_ff;

   always_comb begin
      case (state_ff)
         ST_SCAN: vtx_raddr = VA_W'(tc0);
         ST_V0:   vtx_raddr = VA_W'(corner_ff[1]);
         ST_V1:   vtx_raddr = VA_W'(corner_ff[2]);
         default: vtx_raddr = VA_W'(corner_ff[0]);
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p2[k] = cv_ff[2] ? $signed(vtx_rd_ff[k*POS_W +: POS_W]) : '0;
      end
   end

   // cross(a, b) terms: x = a1*b2 - a2*b1, y = a2*b0 - a0*b2, z = a0*b1 - a1*b0
   always_comb begin
      case (step_ff)
         3'd0:    begin opa = a_ff[1]; opb = b_ff[2]; end
         3'd1:    begin opa = a_ff[2]; opb = b_ff[1]; end
         3'd2:    begin opa = a_ff[2]; opb = b_ff[0]; end
         3'd3:    begin opa = a_ff[0]; opb = b_ff[2]; end
         3'd4:    begin opa = a_ff[0]; opb = b_ff[1]; end
         default: begin opa = a_ff[1]; opb = b_ff[0]; end
      endcase
   end

   always_comb begin
      case (k_ff)
         2'd0:    m_sel = mag_ff[0][ACC_W-1 -: M_W];
         2'd1:    m_sel = mag_ff[1][ACC_W-1 -: M_W];
         default: m_sel = mag_ff[2][ACC_W-1 -: M_W];
      endcase
   end

   always_comb begin
      res_x = neg_ff[0] ? -$signed(q_ff[0]) : $signed(q_ff[0]);
      res_y = neg_ff[1] ? -$signed(q_ff[1]) : $signed(q_ff[1]);
      res_z = neg_ff[2] ? -$signed(q_ff[2]) : $signed(q_ff[2]);
      if (res_y < min_y_ff) begin
         res_y = min_y_ff;
      end
   end

   // memories: writes only while idle, reads registered
   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_VERTEX && 32'(req_slot) < VERTEX_DEPTH) begin
         vtx_mem[VA_W'(req_slot)] <= {req_pos_z, req_pos_y, req_pos_x};
      end
      vtx_rd_ff <= vtx_mem[vtx_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_TRI && 32'(req_slot) < TRIANGLE_DEPTH) begin
         tri_mem[TA_W'(req_slot)] <= {req_corner_c, req_corner_b, req_corner_a};
      end
      tri_rd_ff <= tri_mem[t_ff[TA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (csr_we && csr_index == CSR_TRI_COUNT) begin
         tri_count_ff <= csr_wdata;
      end
      if (csr_we && csr_index == CSR_MIN_Y) begin
         min_y_ff <= $signed(csr_wdata);
      end
      if (reset) begin
         tri_count_ff <= TRI_COUNT_RST;
         min_y_ff     <= MIN_Y_RST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_mode == MODE_QUERY) begin
                  slot_ff <= req_slot;
                  t_ff    <= '0;
                  pend_ff <= 1'b0;
                  for (int k = 0; k < 3; k++) begin
                     acc_ff[k] <= '0;
                  end
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (match) begin
                  corner_ff[0] <= tc0;
                  corner_ff[1] <= tc1;
                  corner_ff[2] <= tc2;
                  cv_ff        <= {32'(tc2) < VERTEX_DEPTH, 32'(tc1) < VERTEX_DEPTH,
                                   32'(tc0) < VERTEX_DEPTH};
                  pend_ff      <= 1'b0;
                  state_ff     <= ST_V0;
               end else if (t_ff < scan_n) begin
                  t_ff    <= t_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_ABS;
               end
            end
            ST_V0: begin
               for (int k = 0; k < 3; k++) begin
                  p0_ff[k] <= cv_ff[0] ? $signed(vtx_rd_ff[k*POS_W +: POS_W]) : '0;
               end
               state_ff <= ST_V1;
            end
            ST_V1: begin
               for (int k = 0; k < 3; k++) begin
                  p1_ff[k] <= cv_ff[1] ? $signed(vtx_rd_ff[k*POS_W +: POS_W]) : '0;
               end
               state_ff <= ST_V2;
            end
            ST_V2: begin
               for (int k = 0; k < 3; k++) begin
                  a_ff[k] <= D_W'(p2[k]) - D_W'(p1_ff[k]);
                  b_ff[k] <= D_W'(p0_ff[k]) - D_W'(p2[k]);
               end
               step_ff  <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= opa * opb;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (step_ff[0]) begin
                  acc_ff[step_ff[2:1]] <= acc_ff[step_ff[2:1]] - ACC_W'(prod_ff);
               end else begin
                  acc_ff[step_ff[2:1]] <= acc_ff[step_ff[2:1]] + ACC_W'(prod_ff);
               end
               step_ff <= step_ff + 1'b1;
               // t_ff already points past the matched triangle
               state_ff <= (step_ff == 3'd5) ? ST_SCAN : ST_MUL;
            end
            ST_ABS: begin
               for (int k = 0; k < 3; k++) begin
                  neg_ff[k] <= acc_ff[k][ACC_W-1];
                  mag_ff[k] <= acc_ff[k][ACC_W-1] ? ACC_W'(-acc_ff[k]) : ACC_W'(acc_ff[k]);
               end
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               if (orv == '0) begin
                  for (int k = 0; k < 3; k++) begin
                     q_ff[k] <= '0;
                  end
                  state_ff <= ST_FIN;
               end else if (orv[ACC_W-1]) begin
                  k_ff     <= '0;
                  len2_ff  <= '0;
                  state_ff <= ST_SQ;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     mag_ff[k] <= mag_ff[k] << 1;
                  end
               end
            end
            ST_SQ: begin
               sq_ff    <= m_sel * m_sel;
               state_ff <= ST_SQACC;
            end
            ST_SQACC: begin
               len2_ff <= len2_ff + L2_W'(sq_ff);
               if (k_ff == 2'd2) begin
                  rv_ff    <= R_W'(len2_ff + L2_W'(sq_ff));
                  root_ff  <= '0;
                  sqb_ff   <= R_W'(1) << (R_W - 2);
                  state_ff <= ST_SQRT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQRT: begin
               if (rv_ff >= sq_try) begin
                  rv_ff   <= rv_ff - sq_try;
                  root_ff <= (root_ff >> 1) + sqb_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               sqb_ff <= sqb_ff >> 2;
               if (sqb_ff[0]) begin
                  k_ff     <= '0;
                  state_ff <= ST_DIVLD;
               end
            end
            ST_DIVLD: begin
               // rounded quotient: (m * 2^14 + len/2) / len
               rem_ff   <= (REM_W'(m_sel) << Q_FRAC) + REM_W'(len >> 1);
               i_ff     <= 4'd15;
               qcur_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (DV_W'(rem_ff) >= dv) begin
                  rem_ff        <= REM_W'(DV_W'(rem_ff) - dv);
                  qcur_ff[i_ff] <= 1'b1;
               end
               i_ff <= i_ff - 1'b1;
               if (i_ff == 4'd0) begin
                  q_ff[k_ff] <= (DV_W'(rem_ff) >= dv) ? (qcur_ff | 16'd1) : qcur_ff;
                  if (k_ff == 2'd2) begin
                     state_ff <= ST_FIN;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= ST_DIVLD;
                  end
               end
            end
            ST_FIN: begin
               rsp_strobe_ff <= 1'b1;
               rsp_id_ff     <= slot_ff[IDX_W-1:0];
               rsp_x_ff      <= res_x;
               rsp_y_ff      <= res_y;
               rsp_z_ff      <= res_z;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_vertex_id = rsp_id_ff;
   assign rsp_normal_x  = rsp_x_ff;
   assign rsp_normal_y  = rsp_y_ff;
   assign rsp_normal_z  = rsp_z_ff;

endmodule
`default_nettype wire

FILE: bench/tb_mesh_vertex_normal_average.sv
// Testbench for mesh_vertex_normal_average: loads meshes, queries vertex normals
// and checks each result word against a predictor. Depends on mvna_pkg and the RTL.
`timescale 1ns / 1ps
module tb_mesh_vertex_normal_average;
   import mvna_pkg::*;

   typedef struct {
      mode_type         mode;
      logic [14:0]      slot;
      logic [31:0]      pos [3];
      logic [13:0]      corner [3];
   } mesh_word_type;

   typedef struct {
      logic [13:0]        vertex_id;
      logic signed [15:0] nx, ny, nz;
   } normal_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_mode = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [IDX_W-1:0] req_corner_a = '0, req_corner_b = '0, req_corner_c = '0;
   logic rsp_strobe;
   logic [IDX_W-1:0] rsp_vertex_id;
   logic signed [NRM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic csr_we = 1'b0;
   logic csr_index = CSR_TRI_COUNT;
   logic [CSR_W-1:0] csr_wdata = '0;

   mesh_vertex_normal_average uut (.*);

   // predictor state
   logic [31:0] vtx_pos [16384][3];
   logic [13:0] tri_corner [32768][3];
   logic [15:0] tri_count_reg = TRI_COUNT_RST;
   logic signed [15:0] floor_y_reg = MIN_Y_RST;
   normal_word_type normal_q [$];
   bit failed = 0;
   int unsigned pool [6];

   initial forever #5 clock = ~clock;

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic normal_word_type vertex_normal(logic [14:0] slot);
      logic signed [127:0] p [3][3];
      logic signed [127:0] ea [3], eb [3], acc [3];
      logic [127:0] mag [3];
      logic [63:0] m [3], len2, len, q;
      logic neg [3];
      int n, bl, maxbl;
      logic signed [15:0] res [3];
      normal_word_type w;
      for (int k = 0; k < 3; k++) acc[k] = 0;
      n = (tri_count_reg > 32768) ? 32768 : tri_count_reg;
      for (int t = 0; t < n; t++) begin
         if (tri_corner[t][0] == slot || tri_corner[t][1] == slot ||
             tri_corner[t][2] == slot) begin
            for (int c = 0; c < 3; c++)
               for (int k = 0; k < 3; k++)
                  p[c][k] = $signed(vtx_pos[tri_corner[t][c]][k]);
            for (int k = 0; k < 3; k++) begin
               ea[k] = p[2][k] - p[1][k];
               eb[k] = p[0][k] - p[2][k];
            end
            acc[0] += ea[1] * eb[2] - ea[2] * eb[1];
            acc[1] += ea[2] * eb[0] - ea[0] * eb[2];
            acc[2] += ea[0] * eb[1] - ea[1] * eb[0];
         end
      end
      maxbl = 0;
      for (int k = 0; k < 3; k++) begin
         neg[k] = acc[k][127];
         mag[k] = neg[k] ? -acc[k] : acc[k];
         bl = 0;
         for (int i = 0; i < 128; i++) if (mag[k][i]) bl = i + 1;
         if (bl > maxbl) maxbl = bl;
      end
      if (maxbl == 0) begin
         for (int k = 0; k < 3; k++) res[k] = 0;
      end else begin
         len2 = 0;
         for (int k = 0; k < 3; k++) begin
            m[k] = (maxbl <= 30) ? 64'(mag[k] << (30 - maxbl))
                                 : 64'(mag[k] >> (maxbl - 30));
            len2 += m[k] * m[k];
         end
         len = int_sqrt(len2);
         for (int k = 0; k < 3; k++) begin
            q = (m[k] * 64'd16384 + len / 2) / len;
            res[k] = neg[k] ? -16'(q) : 16'(q);
         end
      end
      if (res[1] < floor_y_reg) res[1] = floor_y_reg;
      w.vertex_id = slot[13:0];
      w.nx = res[0];
      w.ny = res[1];
      w.nz = res[2];
      return w;
   endfunction

   function automatic void apply_word(mesh_word_type w);
      case (w.mode)
         MODE_VERTEX: if (w.slot < 16384) for (int k = 0; k < 3; k++)
            vtx_pos[w.slot][k] = w.pos[k];
         MODE_TRI: for (int k = 0; k < 3; k++) tri_corner[w.slot][k] = w.corner[k];
         MODE_QUERY: normal_q = {normal_q, vertex_normal(w.slot)};
         default: ;
      endcase
   endfunction

   // start stays high after acceptance; it is lowered only on a gap or by drain_all
   task automatic send_word(mesh_word_type w, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= w.mode;
      req_slot <= w.slot;
      req_pos_x <= w.pos[0];
      req_pos_y <= w.pos[1];
      req_pos_z <= w.pos[2];
      req_corner_a <= w.corner[0];
      req_corner_b <= w.corner[1];
      req_corner_c <= w.corner[2];
      do @(posedge clock); while (busy);
      apply_word(w);
   endtask

   task automatic drain_all();
      start <= 1'b0;
      @(posedge clock);
      while (normal_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      drain_all();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TRI_COUNT) tri_count_reg = value;
      else floor_y_reg = value;
   endtask

   function automatic mesh_word_type noise_word(mode_type mode, int slot);
      mesh_word_type w;
      w.mode = mode;
      w.slot = 15'(slot);
      for (int k = 0; k < 3; k++) begin
         w.pos[k] = $urandom;
         w.corner[k] = 14'($urandom);
      end
      return w;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'h7fffffff + $urandom_range(0, 1);
         default: return $urandom_range(0, 2 << 20) - (1 << 20);
      endcase
   endfunction

   task automatic put_vertex(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             int gap);
      mesh_word_type w;
      w = noise_word(MODE_VERTEX, slot);
      w.pos[0] = x;
      w.pos[1] = y;
      w.pos[2] = z;
      send_word(w, gap);
   endtask

   task automatic put_tri(int slot, int a, int b, int c, int gap);
      mesh_word_type w;
      w = noise_word(MODE_TRI, slot);
      w.corner[0] = 14'(a);
      w.corner[1] = 14'(b);
      w.corner[2] = 14'(c);
      send_word(w, gap);
   endtask

   task automatic query(int slot);
      send_word(noise_word(MODE_QUERY, slot), $urandom_range(0, 10));
   endtask

   always @(posedge clock) begin
      normal_word_type e;
      if (!reset && rsp_strobe) begin
         if (normal_q.size() == 0) begin
            $display("%0t: unexpected word id=%0d", $time, rsp_vertex_id);
            failed = 1;
         end else begin
            e = normal_q.pop_front();
            if (rsp_vertex_id !== e.vertex_id || rsp_normal_x !== e.nx ||
                rsp_normal_y !== e.ny || rsp_normal_z !== e.nz) begin
               $display("%0t: expected id=%0d n=(%0d,%0d,%0d) actual id=%0d n=(%0d,%0d,%0d)",
                        $time, e.vertex_id, e.nx, e.ny, e.nz, rsp_vertex_id,
                        rsp_normal_x, rsp_normal_y, rsp_normal_z);
               failed = 1;
            end
         end
      end
   end

   task automatic test_defaults();
      query(0);                 // nothing scanned: zero sum, default floor
   endtask

   task automatic test_directed();
      put_vertex(0, 0, 0, 0, 1);
      put_vertex(1, 32'h10000, 0, 0, 0);
      put_vertex(2, 0, 0, 32'h10000, 2);
      put_vertex(3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
      put_vertex(4, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
      put_vertex(16383, 32'hffffffff, 32'h12345678, 32'h80000001, 3);
      put_vertex(20000, 1, 2, 3, 0);            // past vertex depth: dropped
      put_tri(0, 0, 1, 2, 0);
      put_tri(1, 3, 4, 16383, 1);
      put_tri(2, 3, 3, 4, 0);                   // repeated corner counts once
      put_tri(3, 0, 2, 1, 0);
      write_csr(CSR_TRI_COUNT, 16'(4));
      query(0);
      query(3);
      query(16383);
      query(16384 + 3);                         // high slot: nothing matches
      send_word(noise_word(MODE_NONE, $urandom), 0);
      query(1);
      write_csr(CSR_MIN_Y, 16'hc000);
      query(1);
      query(4);
      write_csr(CSR_MIN_Y, 16'(16384));
      query(0);
      query(32767);
   endtask

   task automatic test_long_scan();
      put_vertex(100, 32'h10000, 0, 0, 0);
      put_vertex(101, 0, 32'h10000, 0, 0);
      put_vertex(102, 0, 0, 32'h10000, 0);
      for (int t = 4; t < 15; t++) put_tri(t, 100, 101, 102, 0);
      put_tri(15, 3, 4, 0, 0);                  // of triangles 4 to 15, only the last holds 3
      write_csr(CSR_MIN_Y, 16'(0));
      write_csr(CSR_TRI_COUNT, 16'(16));
      query(3);
      query(101);
   endtask

   task automatic test_random_meshes();
      int tris, r, s;
      logic [15:0] floors [4] = '{16'h8000 + 16'h4000, 16'h4000, 16'h0, 16'h0};
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 6; i++)
            pool[i] = (i == 0) ? 16383 : $urandom_range(200, 16383);
         foreach (pool[i]) put_vertex(pool[i], rand_coord(), rand_coord(), rand_coord(),
                                      $urandom_range(0, 10));
         tris = $urandom_range(1, 8);
         for (int t = 0; t < tris; t++)
            put_tri(t, pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)],
                    pool[$urandom_range(0, 5)], $urandom_range(0, 10));
         write_csr(CSR_TRI_COUNT, 16'(tris));
         write_csr(CSR_MIN_Y, (ph == 3) ? 16'($urandom) : floors[ph]);
         for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 99);
            s = pool[$urandom_range(0, 5)];
            if (r < 50) query(s);
            else if (r < 58) query($urandom_range(0, 32767));
            else if (r < 72)
               put_vertex(s, rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 10));
            else if (r < 84)
               put_tri($urandom_range(0, tris - 1), s, pool[$urandom_range(0, 5)],
                       pool[$urandom_range(0, 5)], $urandom_range(0, 10));
            else if (r < 90)
               put_tri($urandom_range(tris, 32767), s, s, pool[$urandom_range(0, 5)],
                       $urandom_range(0, 10));
            else if (r < 95)
               send_word(noise_word(MODE_NONE, $urandom), $urandom_range(0, 10));
            else
               put_vertex($urandom_range(16384, 32767), $urandom, $urandom, $urandom,
                          $urandom_range(0, 10));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_directed();
      test_long_scan();
      test_random_meshes();
      drain_all();
      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
